FILE: rtl/button_press_double_hold_classifier_core_assert.svh
// Assertion macros used by the button classifier RTL
`ifndef BUTTON_PRESS_DOUBLE_HOLD_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_DOUBLE_HOLD_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPDH_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bpdh assertion failed");

// next-cycle implication, disabled in reset
`define BPDH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bpdh assertion failed");

`endif

FILE: rtl/bpdh_pkg.sv
// Package: types and constants for the button press classifier
`timescale 1ns / 1ps
`default_nettype none
package bpdh_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned LimitW = 16;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DOWN     = 2'd1,
        PH_RELEASED = 2'd2
    } phase_t;

    localparam logic [CfgIdxW-1:0] REG_INVERT_LEVEL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DOUBLE_WIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD_LIMIT   = 2'd2;

    localparam logic [LimitW-1:0] DOUBLE_WIN_RESET = 16'd300;
    localparam logic [LimitW-1:0] HOLD_LIMIT_RESET = 16'd1000;

    typedef struct packed {
        logic              invert_level;
        logic [LimitW-1:0] double_window_ms;
        logic [LimitW-1:0] hold_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic             level;
        logic [TimeW-1:0] now_ms;
    } sample_t;

endpackage
`default_nettype wire

FILE: rtl/bpdh_cfg_regs.sv
// Configuration register file for the button press classifier
`timescale 1ns / 1ps
`default_nettype none
module bpdh_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bpdh_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [bpdh_pkg::LimitW-1:0]    cfg_wdata,
    output bpdh_pkg::cfg_t                      cfg
);
    import bpdh_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert_level     <= 1'b0;
            cfg_reg.double_window_ms <= DOUBLE_WIN_RESET;
            cfg_reg.hold_limit_ms    <= HOLD_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INVERT_LEVEL: cfg_reg.invert_level     <= cfg_wdata[0];
                REG_DOUBLE_WIN:   cfg_reg.double_window_ms <= cfg_wdata;
                REG_HOLD_LIMIT:   cfg_reg.hold_limit_ms    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/bpdh_in_stage.sv
// Input register stage for button samples
`timescale 1ns / 1ps
`default_nettype none
module bpdh_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bpdh_pkg::sample_t  s_item,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output bpdh_pkg::sample_t       q_item
);
    import bpdh_pkg::*;

    logic    vld_reg;
    sample_t item_reg;

    assign s_ready = !vld_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = vld_reg;
    assign q_item  = item_reg;

endmodule
`default_nettype wire

FILE: rtl/bpdh_classify.sv
// Edge detection, phase machine and result register
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_double_hold_classifier_core_assert.svh"
module bpdh_classify (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bpdh_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire bpdh_pkg::sample_t  q_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_event_res
);
    import bpdh_pkg::*;

    phase_t           phase_reg, phase_next;
    logic             last_level_reg;
    logic [TimeW-1:0] press_time_reg, press_time_next;
    logic             out_vld_reg;
    event_t           event_reg, event_next;

    logic             lvl;
    logic             rise;
    logic             fall;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] win_ext;
    logic [TimeW-1:0] hold_ext;
    logic             adv;

    assign q_ready = !out_vld_reg || m_ready;
    assign adv     = q_valid && q_ready;

    assign lvl      = q_item.level ^ cfg.invert_level;
    assign rise     = lvl && !last_level_reg;
    assign fall     = !lvl && last_level_reg;
    assign elapsed  = q_item.now_ms - press_time_reg;
    assign win_ext  = {{(TimeW-LimitW){1'b0}}, cfg.double_window_ms};
    assign hold_ext = {{(TimeW-LimitW){1'b0}}, cfg.hold_limit_ms};

    always_comb begin
        phase_next      = phase_reg;
        press_time_next = press_time_reg;
        event_next      = EV_NONE;
        case (phase_reg)
            PH_DOWN: begin
                if (fall) begin
                    phase_next = PH_RELEASED;
                end else if (elapsed > hold_ext) begin
                    phase_next = PH_IDLE;
                    event_next = EV_HOLD;
                end
            end
            PH_RELEASED: begin
                if (rise && (elapsed < win_ext)) begin
                    phase_next = PH_IDLE;
                    event_next = EV_DOUBLE;
                end else if (elapsed > win_ext) begin
                    phase_next = PH_IDLE;
                    event_next = EV_SINGLE;
                end
            end
            default: begin
                if (rise) begin
                    phase_next      = PH_DOWN;
                    press_time_next = q_item.now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            last_level_reg <= 1'b0;
            press_time_reg <= '0;
        end else if (adv) begin
            phase_reg      <= phase_next;
            last_level_reg <= lvl;
            press_time_reg <= press_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (q_ready) begin
            out_vld_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            event_reg <= event_next;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_event_res = event_reg;

    `BPDH_ASSERT_NEXT(a_idle_no_event, aclk, aresetn,
        adv && (phase_reg == PH_IDLE), event_reg == EV_NONE)
    `BPDH_ASSERT_NEXT(a_event_to_idle, aclk, aresetn,
        adv && (event_next != EV_NONE), phase_reg == PH_IDLE)
    `BPDH_ASSERT_NEXT(a_press_time_hold, aclk, aresetn,
        !(adv && (phase_reg == PH_IDLE)), $stable(press_time_reg))
    `BPDH_ASSERT_SAME(a_hold_from_down, aclk, aresetn,
        adv && (event_next == EV_HOLD), phase_reg == PH_DOWN)

endmodule
`default_nettype wire

FILE: rtl/button_press_double_hold_classifier_core.sv
// Top level: button press classifier (single, double, hold)
// A sample transfer passes through the input register, then the result register; back-pressure can stall either.
// Throughput: one sample per cycle while m_ready holds; one result per sample, set by the single result register.
// Reset: synchronous active-low aresetn clears valids, phase, last level and press time,
// and loads config defaults (invert 0, double window 300 ms, hold limit 1000 ms).
`timescale 1ns / 1ps
`default_nettype none
module button_press_double_hold_classifier_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bpdh_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [bpdh_pkg::LimitW-1:0]    cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_level,
    input  wire logic [bpdh_pkg::TimeW-1:0]     s_now_ms,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_event_res
);
    import bpdh_pkg::*;

    cfg_t    cfg;
    sample_t s_item;
    sample_t q_item;
    logic    q_valid;
    logic    q_ready;

    assign s_item.level  = s_level;
    assign s_item.now_ms = s_now_ms;

    bpdh_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpdh_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    bpdh_classify u_cls (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res)
    );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the button press classifier: predicted single, double and hold events
`timescale 1ns / 1ps

module tb_top;
    import bpdh_pkg::*;

    class button_event_tracker;
        cfg_t             cfg;
        phase_t           phase;
        logic             last_level;
        logic [TimeW-1:0] press_time;
        event_t           expected_events[$];
        int unsigned      mismatches;
        int unsigned      results_checked;
        int unsigned      event_tally[4];

        function new();
            cfg.invert_level     = 1'b0;
            cfg.double_window_ms = DOUBLE_WIN_RESET;
            cfg.hold_limit_ms    = HOLD_LIMIT_RESET;
            phase                = PH_IDLE;
            last_level           = 1'b0;
            press_time           = '0;
            mismatches           = 0;
            results_checked      = 0;
            foreach (event_tally[i]) event_tally[i] = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] data);
            case (idx)
                REG_INVERT_LEVEL: cfg.invert_level = data[0];
                REG_DOUBLE_WIN:   cfg.double_window_ms = data;
                REG_HOLD_LIMIT:   cfg.hold_limit_ms = data;
                default: ;
            endcase
        endfunction

        // advance the press machine by one accepted sample and queue its event
        function void note_sample(logic level, logic [TimeW-1:0] now_ms);
            logic             lvl;
            logic             rise;
            logic             fall;
            logic [TimeW-1:0] elapsed;
            event_t           ev;
            lvl     = level ^ cfg.invert_level;
            rise    = lvl && !last_level;
            fall    = !lvl && last_level;
            elapsed = now_ms - press_time;
            ev      = EV_NONE;
            case (phase)
                PH_DOWN: begin
                    if (fall) begin
                        phase = PH_RELEASED;
                    end else if (elapsed > cfg.hold_limit_ms) begin
                        phase = PH_IDLE;
                        ev    = EV_HOLD;
                    end
                end
                PH_RELEASED: begin
                    if (rise && elapsed < cfg.double_window_ms) begin
                        phase = PH_IDLE;
                        ev    = EV_DOUBLE;
                    end else if (elapsed > cfg.double_window_ms) begin
                        phase = PH_IDLE;
                        ev    = EV_SINGLE;
                    end
                end
                default: begin
                    if (rise) begin
                        phase      = PH_DOWN;
                        press_time = now_ms;
                    end
                end
            endcase
            last_level = lvl;
            expected_events.push_back(ev);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_event(logic [1:0] got);
            event_t exp;
            if (expected_events.size() == 0) begin
                report($sformatf("event %0d with no sample outstanding", got));
            end else begin
                exp = expected_events.pop_front();
                results_checked++;
                event_tally[int'(exp)]++;
                if (got !== exp) begin
                    report($sformatf("event_res got %0d, expected %0d (%s)", got, exp,
                                     exp.name()));
                end
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [LimitW-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_level;
    logic [TimeW-1:0]     s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_event_res;

    button_event_tracker  tracker;
    bit                   steady;
    bit                   cur_inv;
    int                   win_ms;
    int                   hold_ms;
    int unsigned          samples_sent;
    int unsigned          settings_run;
    logic [TimeW-1:0]     clock_ms;

    button_press_double_hold_classifier_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_level     (s_level),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[button_press_double_hold_classifier_core] ERROR");
        $finish;
    end

    // result side: check each transfer, stall at random unless steady
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_event(m_event_res);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 15);
        end
    end

    task send_sample(input bit logical, input logic [TimeW-1:0] now_ms);
        if (!steady && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_level  <= logical ^ cur_inv;
        s_now_ms <= now_ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_sample(logical ^ cur_inv, now_ms);
        samples_sent++;
    endtask

    task drain_results();
        s_valid <= 1'b0;
        while (tracker.expected_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_config(input bit inv, input int unsigned win, input int unsigned hold);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INVERT_LEVEL;
        cfg_wdata <= LimitW'(inv);
        @(posedge aclk);
        cfg_index <= REG_DOUBLE_WIN;
        cfg_wdata <= LimitW'(win);
        @(posedge aclk);
        cfg_index <= REG_HOLD_LIMIT;
        cfg_wdata <= LimitW'(hold);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.write_reg(REG_INVERT_LEVEL, LimitW'(inv));
        tracker.write_reg(REG_DOUBLE_WIN, LimitW'(win));
        tracker.write_reg(REG_HOLD_LIMIT, LimitW'(hold));
        cur_inv = inv;
        win_ms  = win;
        hold_ms = hold;
        settings_run++;
    endtask

    // one press gesture with sample times clustered around the window and hold limits, or one to four random samples
    task play_gesture();
        int unsigned      kind;
        int unsigned      n;
        int unsigned      k;
        int               off;
        int               target;
        int               span;
        logic [7:0]       pattern;
        logic [TimeW-1:0] base;
        span = (win_ms > hold_ms) ? win_ms : hold_ms;
        kind = $urandom_range(0, 7);
        if (kind == 7) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    clock_ms = $urandom();
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, 2 * span + 2);
                end
                send_sample(1'($urandom_range(0, 1)), clock_ms);
            end
        end else begin
            case (kind)
                0, 1: begin
                    pattern = 8'b0000_0001;
                    n       = 4;
                end
                2, 3: begin
                    pattern = 8'b0000_0101;
                    n       = 5;
                end
                4: begin
                    pattern = 8'b0000_0111;
                    n       = 5;
                end
                5: begin
                    pattern = 8'b0000_1101;
                    n       = 5;
                end
                default: begin
                    pattern = 8'($urandom()) | 8'h01;
                    n       = $urandom_range(2, 8);
                end
            endcase
            case ($urandom_range(0, 19))
                0:       base = $urandom();
                1:       base = 32'hFFFF_FFFF - $urandom_range(0, span);
                default: base = clock_ms + $urandom_range(1, 100);
            endcase
            off = 0;
            for (k = 0; k < n; k++) begin
                if (k > 0) begin
                    case ($urandom_range(0, 7))
                        0:       target = win_ms - 1;
                        1:       target = win_ms;
                        2:       target = win_ms + 1;
                        3:       target = hold_ms - 1;
                        4:       target = hold_ms;
                        5:       target = hold_ms + 1;
                        6:       target = off + $urandom_range(0, 20);
                        default: target = $urandom_range(0, span + 2);
                    endcase
                    if (target < off) begin
                        target = off + $urandom_range(0, 2);
                    end
                    off = target;
                end
                send_sample(pattern[k], base + TimeW'(off));
            end
            // release and step the time past both limits, counted from the gesture start
            off = ((off > span) ? off : span) + 1 + $urandom_range(0, 3);
            send_sample(1'b0, base + TimeW'(off));
            send_sample(1'b0, base + TimeW'(off + 1));
            clock_ms = base + TimeW'(off + 1);
        end
    endtask

    initial begin
        int setting;
        tracker      = new();
        steady       = 1'b0;
        cur_inv      = 1'b0;
        win_ms       = int'(DOUBLE_WIN_RESET);
        hold_ms      = int'(HOLD_LIMIT_RESET);
        samples_sent = 0;
        settings_run = 0;
        clock_ms     = '0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_INVERT_LEVEL;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_level   <= 1'b0;
        s_now_ms  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: window 300, hold 1000
        send_sample(1'b1, 32'd100);
        send_sample(1'b0, 32'd150);
        send_sample(1'b0, 32'd400);
        send_sample(1'b0, 32'd401);
        send_sample(1'b1, 32'd1000);
        send_sample(1'b0, 32'd1050);
        send_sample(1'b1, 32'd1299);
        send_sample(1'b0, 32'd1310);
        send_sample(1'b1, 32'd2000);
        send_sample(1'b1, 32'd3000);
        send_sample(1'b1, 32'd3001);
        send_sample(1'b1, 32'd3100);
        send_sample(1'b0, 32'd3200);
        send_sample(1'b1, 32'd4000);
        send_sample(1'b0, 32'd4050);
        send_sample(1'b1, 32'd4400);
        send_sample(1'b1, 32'd4410);
        send_sample(1'b0, 32'd4420);
        send_sample(1'b1, 32'd5000);
        send_sample(1'b0, 32'd5100);
        send_sample(1'b1, 32'd5300);
        send_sample(1'b1, 32'd5301);
        send_sample(1'b1, 32'hFFFF_FF00);
        send_sample(1'b0, 32'hFFFF_FF80);
        send_sample(1'b1, 32'h0000_0020);
        send_sample(1'b0, 32'hFFFF_FFFF);
        clock_ms = 32'd6000;

        for (setting = 0; setting < 6; setting++) begin
            drain_results();
            case (setting)
                0: write_config(1'b0, 32'(DOUBLE_WIN_RESET), 32'(HOLD_LIMIT_RESET));
                1: write_config(1'b1, 0, 0);
                2: write_config(1'b0, 65535, 65535);
                3: write_config(1'b1, 20, 5);
                4: write_config(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535));
                default: write_config(1'b1, $urandom_range(0, 50), 65535);
            endcase
            steady = (setting == 2);
            while (samples_sent < 26 + (setting + 1) * 265) play_gesture();
        end
        steady = 1'b0;
        drain_results();

        $display("ran %0d samples over %0d register settings, both polarities and zero/full limits",
                 samples_sent, settings_run);
        $display("checked %0d results: %0d single, %0d double, %0d hold, %0d quiet",
                 tracker.results_checked, tracker.event_tally[int'(EV_SINGLE)],
                 tracker.event_tally[int'(EV_DOUBLE)], tracker.event_tally[int'(EV_HOLD)],
                 tracker.event_tally[int'(EV_NONE)]);
        if (tracker.mismatches == 0) begin
            $display("[button_press_double_hold_classifier_core] OK");
        end else begin
            $display("[button_press_double_hold_classifier_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bpdh_pkg.sv
rtl/bpdh_cfg_regs.sv
rtl/bpdh_in_stage.sv
rtl/bpdh_classify.sv
rtl/button_press_double_hold_classifier_core.sv
test/tb_top.sv
